### sv/npas_pkg.sv
// ----------------------------------------------------------------------------
// npas_pkg
// Shared types, codes and helpers of the nibble precision ALU stack.
// ----------------------------------------------------------------------------
package npas_pkg;

  localparam int unsigned DefRegCount   = 16;
  localparam int unsigned DefStackDepth = 16;

  localparam logic [2:0] OpPush = 3'd0;
  localparam logic [2:0] OpPop  = 3'd1;
  localparam logic [2:0] OpNeg  = 3'd2;
  localparam logic [2:0] OpAdd  = 3'd3;
  localparam logic [2:0] OpSub  = 3'd4;
  localparam logic [2:0] OpLoad = 3'd5;

  localparam logic [1:0] StatusDone    = 2'd0;
  localparam logic [1:0] StatusBadReg  = 2'd1;
  localparam logic [1:0] StatusBadPrec = 2'd2;

  localparam logic [2:0] MaxPrecision = 3'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg;
    logic [2:0]  precision;
    logic [15:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        zero_flag;
    logic [15:0] dest_value;
    logic [1:0]  extra_delay;
  } out_item_t;

  typedef enum logic [2:0] {
    KindNop,
    KindPush,
    KindPop,
    KindNeg,
    KindAdd,
    KindSub,
    KindLoad
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  status;
    logic        dst_ok;
    logic [4:0]  dst_reg;
    logic [4:0]  src_reg;
    logic [1:0]  prec;
    logic [15:0] load_value;
  } dec_item_t;

  function automatic logic [15:0] nib_mask(input logic [1:0] prec);
    logic [15:0] m;
    case (prec)
      2'd0:    m = 16'h000f;
      2'd1:    m = 16'h00ff;
      2'd2:    m = 16'h0fff;
      default: m = 16'hffff;
    endcase
    return m;
  endfunction

endpackage

### sv/nibble_precision_alu_stack.sv
// ----------------------------------------------------------------------------
// nibble_precision_alu_stack
// Nibble precision ALU with a register file and a ring stack.
//
//   Channel  Handshake             Payload
//   input    in_valid_i/in_ready_o   in_data_i  (npas_pkg::in_item_t)
//   output   out_valid_o/out_ready_i out_data_o (npas_pkg::out_item_t)
//
// One transaction per cycle is sustained while the output is accepted; each
// instruction passes through the queue and the register file and stack read
// stage and then sits in the output register.
// Reset clears the stack pointer and the zero flag, and the register file and
// the stack through per-entry valid bits; no clearing pass is needed.
// A stalled output holds the execute stage; the queue keeps taking input
// until its two entries are full.
// ----------------------------------------------------------------------------
module nibble_precision_alu_stack #(
  parameter int unsigned REG_COUNT   = npas_pkg::DefRegCount,
  parameter int unsigned STACK_DEPTH = npas_pkg::DefStackDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  npas_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output npas_pkg::out_item_t out_data_o
);
  import npas_pkg::*;

  logic      q_full;
  logic      q_push;
  dec_item_t q_push_data;
  logic      q_valid;
  logic      q_pop;
  dec_item_t q_pop_data;

  npas_front #(
    .REG_COUNT(REG_COUNT)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_push_data)
  );

  npas_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_pop_data)
  );

  npas_back #(
    .REG_COUNT  (REG_COUNT),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_pop_data),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### sv/npas_front.sv
// ----------------------------------------------------------------------------
// npas_front
// Accepts instructions, checks register numbers and precision, and hands a
// classified instruction to the queue.
// ----------------------------------------------------------------------------
module npas_front #(
  parameter int unsigned REG_COUNT = npas_pkg::DefRegCount
) (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  npas_pkg::in_item_t  in_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output npas_pkg::dec_item_t q_data_o
);
  import npas_pkg::*;

  logic dst_ok;
  logic src_ok;

  assign dst_ok = ({2'b00, in_data_i.dest_reg} != 7'd0) &&
                  ({2'b00, in_data_i.dest_reg} <= 7'(REG_COUNT));
  assign src_ok = ({2'b00, in_data_i.src_reg} != 7'd0) &&
                  ({2'b00, in_data_i.src_reg} <= 7'(REG_COUNT));

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o            = '0;
    q_data_o.kind       = KindNop;
    q_data_o.status     = StatusDone;
    q_data_o.dst_ok     = dst_ok;
    q_data_o.dst_reg    = in_data_i.dest_reg;
    q_data_o.src_reg    = in_data_i.src_reg;
    q_data_o.prec       = in_data_i.precision[1:0];
    q_data_o.load_value = in_data_i.load_value;
    case (in_data_i.operation)
      OpPush, OpPop, OpLoad: begin
        if (!dst_ok) begin
          q_data_o.status = StatusBadReg;
        end else if (in_data_i.operation == OpPush) begin
          q_data_o.kind = KindPush;
        end else if (in_data_i.operation == OpPop) begin
          q_data_o.kind = KindPop;
        end else begin
          q_data_o.kind = KindLoad;
        end
      end
      OpNeg, OpAdd, OpSub: begin
        if (in_data_i.precision > MaxPrecision) begin
          q_data_o.status = StatusBadPrec;
        end else if (!dst_ok || !src_ok) begin
          q_data_o.status = StatusBadReg;
        end else if (in_data_i.operation == OpNeg) begin
          q_data_o.kind = KindNeg;
        end else if (in_data_i.operation == OpAdd) begin
          q_data_o.kind = KindAdd;
        end else begin
          q_data_o.kind = KindSub;
        end
      end
      default: begin
        q_data_o.kind = KindNop;
      end
    endcase
  end

endmodule

### sv/npas_fifo.sv
// ----------------------------------------------------------------------------
// npas_fifo
// Two-entry queue of classified instructions between front and back.
// ----------------------------------------------------------------------------
module npas_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  npas_pkg::dec_item_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output npas_pkg::dec_item_t pop_data_o
);
  import npas_pkg::*;

  dec_item_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/npas_back.sv
// ----------------------------------------------------------------------------
// npas_back
// Executes classified instructions: reads the register file and stack in
// one stage, computes and writes back in the next, and holds the result in
// an output register.
// ----------------------------------------------------------------------------
module npas_back #(
  parameter int unsigned REG_COUNT   = npas_pkg::DefRegCount,
  parameter int unsigned STACK_DEPTH = npas_pkg::DefStackDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  npas_pkg::dec_item_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output npas_pkg::out_item_t out_data_o
);
  import npas_pkg::*;

  localparam int unsigned RW = $clog2(REG_COUNT);
  localparam int unsigned SW = $clog2(STACK_DEPTH);

  logic [15:0]      rf_mem  [REG_COUNT];
  logic [15:0]      stk_mem [STACK_DEPTH];
  logic [REG_COUNT-1:0]   rf_vld_q;
  logic [STACK_DEPTH-1:0] stk_vld_q;

  logic [SW-1:0] sp_q, sp_d;
  logic          zero_q, zero_d;

  logic      a_valid_q;
  dec_item_t a_item_q;
  logic [15:0] src_rd_q, dst_rd_q, stk_rd_q;
  logic        src_vld_q, dst_vld_q, stk_vld_rd_q;
  logic          rf_fw_en_q;
  logic [RW-1:0] rf_fw_addr_q;
  logic [15:0]   rf_fw_data_q;
  logic          stk_fw_en_q;
  logic [SW-1:0] stk_fw_addr_q;
  logic [15:0]   stk_fw_data_q;

  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic a_advance;
  logic a_load;

  logic [RW-1:0] h_src_idx, h_dst_idx, a_src_idx, a_dst_idx;
  logic [SW-1:0] sp_after_a, stk_raddr, a_stk_addr;
  logic [6:0]    h_src_m1, h_dst_m1, a_src_m1, a_dst_m1;

  logic [15:0] src_val, dst_val, stk_val, mask, low, new_d;
  logic        rf_we;
  logic [15:0] rf_wdata;
  logic        stk_we;

  function automatic logic [SW-1:0] sp_inc(input logic [SW-1:0] sp);
    return (sp == SW'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
  endfunction

  function automatic logic [SW-1:0] sp_dec(input logic [SW-1:0] sp);
    return (sp == '0) ? SW'(STACK_DEPTH - 1) : sp - 1'b1;
  endfunction

  assign a_advance = a_valid_q && (!out_valid_q || out_ready_i);
  assign a_load    = q_valid_i && (!a_valid_q || a_advance);
  assign q_pop_o   = a_load;

  assign h_src_m1  = {2'b00, q_data_i.src_reg} - 7'd1;
  assign h_dst_m1  = {2'b00, q_data_i.dst_reg} - 7'd1;
  assign a_src_m1  = {2'b00, a_item_q.src_reg} - 7'd1;
  assign a_dst_m1  = {2'b00, a_item_q.dst_reg} - 7'd1;
  assign h_src_idx = h_src_m1[RW-1:0];
  assign h_dst_idx = h_dst_m1[RW-1:0];
  assign a_src_idx = a_src_m1[RW-1:0];
  assign a_dst_idx = a_dst_m1[RW-1:0];

  assign a_stk_addr = (a_item_q.kind == KindPush) ? sp_q : sp_dec(sp_q);

  always_comb begin
    sp_d = sp_q;
    if (a_valid_q && a_item_q.kind == KindPush) begin
      sp_d = sp_inc(sp_q);
    end else if (a_valid_q && a_item_q.kind == KindPop) begin
      sp_d = sp_dec(sp_q);
    end
  end

  assign sp_after_a = sp_d;
  assign stk_raddr  = sp_dec(sp_after_a);

  always_comb begin
    src_val = src_vld_q ? src_rd_q : 16'h0000;
    if (rf_fw_en_q && rf_fw_addr_q == a_src_idx) begin
      src_val = rf_fw_data_q;
    end
    dst_val = dst_vld_q ? dst_rd_q : 16'h0000;
    if (rf_fw_en_q && rf_fw_addr_q == a_dst_idx) begin
      dst_val = rf_fw_data_q;
    end
    stk_val = stk_vld_rd_q ? stk_rd_q : 16'h0000;
    if (stk_fw_en_q && stk_fw_addr_q == a_stk_addr) begin
      stk_val = stk_fw_data_q;
    end

    mask   = nib_mask(a_item_q.prec);
    low    = 16'h0000;
    new_d  = dst_val;
    zero_d = zero_q;
    rf_we  = 1'b0;
    stk_we = 1'b0;
    out_d.extra_delay = 2'd0;
    case (a_item_q.kind)
      KindPush: begin
        stk_we = 1'b1;
      end
      KindPop: begin
        new_d = stk_val;
        rf_we = 1'b1;
      end
      KindLoad: begin
        new_d = a_item_q.load_value;
        rf_we = 1'b1;
      end
      KindNeg, KindAdd, KindSub: begin
        if (a_item_q.kind == KindNeg) begin
          low = (16'h0000 - src_val) & mask;
        end else if (a_item_q.kind == KindAdd) begin
          low = (dst_val + src_val) & mask;
        end else begin
          low = (dst_val - src_val) & mask;
        end
        new_d  = (dst_val & ~mask) | low;
        zero_d = (low == 16'h0000);
        rf_we  = 1'b1;
        out_d.extra_delay = a_item_q.prec;
      end
      default: begin
        new_d = dst_val;
      end
    endcase
    rf_we    = rf_we && a_advance;
    stk_we   = stk_we && a_advance;
    rf_wdata = new_d;

    out_d.status     = a_item_q.status;
    out_d.zero_flag  = zero_d;
    out_d.dest_value = a_item_q.dst_ok ? new_d : 16'h0000;
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[a_dst_idx] <= rf_wdata;
    end
    if (stk_we) begin
      stk_mem[sp_q] <= dst_val;
    end
    if (a_load) begin
      src_rd_q <= rf_mem[h_src_idx];
      dst_rd_q <= rf_mem[h_dst_idx];
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_item_q      <= q_data_i;
      src_vld_q     <= rf_vld_q[h_src_idx];
      dst_vld_q     <= rf_vld_q[h_dst_idx];
      stk_vld_rd_q  <= stk_vld_q[stk_raddr];
      rf_fw_en_q    <= rf_we;
      rf_fw_addr_q  <= a_dst_idx;
      rf_fw_data_q  <= rf_wdata;
      stk_fw_en_q   <= stk_we;
      stk_fw_addr_q <= sp_q;
      stk_fw_data_q <= dst_val;
    end
    if (a_advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q    <= '0;
      stk_vld_q   <= '0;
      sp_q        <= '0;
      zero_q      <= 1'b0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_q[a_dst_idx] <= 1'b1;
      end
      if (stk_we) begin
        stk_vld_q[sp_q] <= 1'b1;
      end
      if (a_advance) begin
        sp_q   <= sp_d;
        zero_q <= zero_d;
      end
      if (a_load) begin
        a_valid_q <= 1'b1;
      end else if (a_advance) begin
        a_valid_q <= 1'b0;
      end
      if (a_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
